### rtl/core/ltms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Literal text match scanner package
// Shared constants, types, register indexes and byte and counter helper functions.
// ----------------------------------------------------------------------------
package ltms_pkg;

   localparam int unsigned QUERY_SLOTS         = 16;
   localparam int unsigned MAX_QUERY_BYTES_DEF = 16;
   localparam int unsigned MAX_LINE_BYTES_DEF  = 4096;
   localparam int unsigned QLEN_W              = 5;
   localparam int unsigned COUNT_W             = 16;
   localparam int unsigned COLUMN_W            = 12;
   localparam int unsigned CSR_DATA_W          = 64;
   localparam int unsigned CSR_INDEX_W         = 3;

   typedef logic [7:0]                   byte_type;
   typedef logic [QUERY_SLOTS-1:0][7:0]  query_bytes_type;
   typedef logic [QLEN_W-1:0]            qlen_type;
   typedef logic [COUNT_W-1:0]           count_type;
   typedef logic [COLUMN_W-1:0]          column_type;
   typedef logic [CSR_DATA_W-1:0]        csr_data_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUERY_LOW      = 3'd0,
      CSR_QUERY_HIGH     = 3'd1,
      CSR_QUERY_LENGTH   = 3'd2,
      CSR_CASE_SENSITIVE = 3'd3,
      CSR_WHOLE_WORD     = 3'd4,
      CSR_MAX_RESULTS    = 3'd5
   } csr_index_type;

   function automatic byte_type fold_byte(input byte_type value, input logic case_sensitive);
      byte_type result;
      result = value;
      if (!case_sensitive && value >= 8'h41 && value <= 8'h5A) begin
         result = value + 8'h20;
      end
      return result;
   endfunction

   function automatic logic is_alnum(input byte_type value);
      return (value >= 8'h30 && value <= 8'h39) || (value >= 8'h41 && value <= 8'h5A) ||
             (value >= 8'h61 && value <= 8'h7A);
   endfunction

   function automatic count_type sat_inc(input count_type value);
      return (value == '1) ? value : value + count_type'(1);
   endfunction

endpackage : ltms_pkg
`default_nettype wire

### rtl/core/ltms_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Literal text match scanner channels
// Valid/ready channels for text items and match report items.
// ----------------------------------------------------------------------------
interface ltms_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_line;
   logic       new_file;
   logic       new_search;

   modport source (output valid, text_byte, end_of_line, new_file, new_search, input ready);
   modport sink   (input valid, text_byte, end_of_line, new_file, new_search, output ready);
endinterface : ltms_req_if

interface ltms_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] file_number;
   logic [15:0] line_number;
   logic [11:0] column;
   logic [4:0]  match_length;

   modport source (output valid, file_number, line_number, column, match_length, input ready);
   modport sink   (input valid, file_number, line_number, column, match_length, output ready);
endinterface : ltms_rsp_if
`default_nettype wire

### rtl/core/ltms_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Literal text match scanner window cell
// Holds one byte of the text window, passes it to the next cell on a shift
// and compares the byte entering it with its query byte.
// ----------------------------------------------------------------------------
module ltms_cell #(
   parameter int unsigned CELL_INDEX = 0
) (
   input  wire                        clock,
   input  wire                        shift_en,
   input  wire ltms_pkg::byte_type        byte_in,
   input  wire ltms_pkg::query_bytes_type query,
   input  wire ltms_pkg::qlen_type        qlen,
   input  wire                        case_sensitive,
   output ltms_pkg::byte_type             byte_out,
   output logic                       hit
);
   import ltms_pkg::*;

   byte_type               byte_ff;
   logic [QLEN_W-1:0]      qpos;
   logic [3:0]             qidx;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   // Cell j lines up with query byte qlen-1-j once the new byte is in.
   always_comb begin
      qpos = qlen - QLEN_W'(CELL_INDEX) - QLEN_W'(1);
      qidx = qpos[3:0];
      hit  = (qlen <= QLEN_W'(CELL_INDEX)) ||
             (fold_byte(byte_in, case_sensitive) == fold_byte(query[qidx], case_sensitive));
   end

   assign byte_out = byte_ff;

endmodule : ltms_cell
`default_nettype wire

### rtl/core/literal_text_match_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Literal text match scanner
// A report appears on the rsp channel from the output register in the cycle
// after the item that causes it. Throughput: one text item per cycle, set by
// the combinational compare across the window cells; input stalls only while
// a report waits in the output register. Reset is synchronous and clears the
// counters, the pending match, the output valid and the CSRs to reset values.
// ----------------------------------------------------------------------------
module literal_text_match_scanner #(
   parameter int unsigned MAX_QUERY_BYTES = ltms_pkg::MAX_QUERY_BYTES_DEF,
   parameter int unsigned MAX_LINE_BYTES  = ltms_pkg::MAX_LINE_BYTES_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_write_enable,
   input  wire [ltms_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire ltms_pkg::csr_data_type csr_write_data,
   ltms_req_if.sink                req_chan,
   ltms_rsp_if.source              rsp_chan
);
   import ltms_pkg::*;

   localparam int unsigned CW = $clog2(MAX_LINE_BYTES + 1);

   // Registers
   logic [63:0]  query_low_ff, query_high_ff;
   qlen_type     query_length_ff;
   logic         case_sensitive_ff, whole_word_ff;
   count_type    max_results_ff;

   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] nas_ff, nas_in;
   logic [CW-1:0] pcol_ff, pcol_in;
   logic          pend_ff, pend_in;
   count_type     line_ff, line_in;
   count_type     file_ff, file_in;
   count_type     rcount_ff, rcount_in;

   logic       rsp_valid_ff, rsp_valid_in;
   count_type  rsp_file_ff, rsp_file_in;
   count_type  rsp_line_ff, rsp_line_in;
   column_type rsp_col_ff, rsp_col_in;
   qlen_type   rsp_len_ff;

   query_bytes_type                     query;
   qlen_type                            qlen;
   logic [MAX_QUERY_BYTES-1:0][7:0]     cell_byte;
   logic [MAX_QUERY_BYTES-1:0]          cell_hit;
   logic                                accept;
   logic                                shift_en;

   logic          clear_nfns, pend_fire, imm_fire, cand, enough;
   logic [CW-1:0] col_base, nas_base, start;
   count_type     line_base, file_mid, rc_mid;
   byte_type      bnd_byte;

   assign query = {query_high_ff, query_low_ff};
   assign qlen  = (query_length_ff > QLEN_W'(MAX_QUERY_BYTES)) ?
                  QLEN_W'(MAX_QUERY_BYTES) : query_length_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_low_ff      <= '0;
         query_high_ff     <= '0;
         query_length_ff   <= QLEN_W'(1);
         case_sensitive_ff <= 1'b0;
         whole_word_ff     <= 1'b0;
         max_results_ff    <= '1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_QUERY_LOW:      query_low_ff      <= csr_write_data;
            CSR_QUERY_HIGH:     query_high_ff     <= csr_write_data;
            CSR_QUERY_LENGTH:   query_length_ff   <= csr_write_data[QLEN_W-1:0];
            CSR_CASE_SENSITIVE: case_sensitive_ff <= csr_write_data[0];
            CSR_WHOLE_WORD:     whole_word_ff     <= csr_write_data[0];
            CSR_MAX_RESULTS:    max_results_ff    <= csr_write_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   genvar j;
   generate
      for (j = 0; j < MAX_QUERY_BYTES; j++) begin : g_cell
         ltms_cell #(
            .CELL_INDEX (j)
         ) u_cell (
            .clock          (clock),
            .shift_en       (shift_en),
            .byte_in        ((j == 0) ? req_chan.text_byte : cell_byte[(j == 0) ? 0 : j - 1]),
            .query          (query),
            .qlen           (qlen),
            .case_sensitive (case_sensitive_ff),
            .byte_out       (cell_byte[j]),
            .hit            (cell_hit[j])
         );
      end
   endgenerate

   // The byte just before a candidate sits at window position qlen after the shift.
   always_comb begin
      bnd_byte = '0;
      for (int unsigned k = 0; k < MAX_QUERY_BYTES; k++) begin
         if (qlen == QLEN_W'(k + 1)) begin
            bnd_byte = cell_byte[k];
         end
      end
   end

   always_comb begin
      col_in      = col_ff;
      nas_in      = nas_ff;
      pcol_in     = pcol_ff;
      pend_in     = pend_ff;
      line_in     = line_ff;
      file_in     = file_ff;
      rcount_in   = rcount_ff;
      shift_en    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_file_in = rsp_file_ff;
      rsp_line_in = rsp_line_ff;
      rsp_col_in  = rsp_col_ff;

      clear_nfns = req_chan.new_file || req_chan.new_search;
      pend_fire  = pend_ff && (qlen != '0) && (rcount_ff < max_results_ff) &&
                   (req_chan.end_of_line || clear_nfns || !is_alnum(req_chan.text_byte));
      rc_mid     = req_chan.new_search ? '0 : (pend_fire ? sat_inc(rcount_ff) : rcount_ff);
      file_mid   = req_chan.new_search ? '0 : file_ff;
      if (req_chan.new_file) begin
         file_mid = sat_inc(file_mid);
      end
      line_base  = clear_nfns ? count_type'(1) : line_ff;
      col_base   = clear_nfns ? '0 : col_ff;
      nas_base   = clear_nfns ? '0 : nas_ff;
      enough     = (col_base + CW'(1)) >= CW'(qlen);
      start      = col_base + CW'(1) - CW'(qlen);
      cand       = (qlen != '0) && enough && (start >= nas_base) && (&cell_hit);
      imm_fire   = 1'b0;

      if (accept) begin
         pend_in   = 1'b0;
         file_in   = file_mid;
         col_in    = col_base;
         nas_in    = nas_base;
         rcount_in = rc_mid;
         if (req_chan.end_of_line) begin
            line_in = sat_inc(line_base);
            col_in  = '0;
            nas_in  = '0;
         end else begin
            line_in = line_base;
            if (col_base < CW'(MAX_LINE_BYTES)) begin
               shift_en = 1'b1;
               col_in   = col_base + CW'(1);
               if (cand) begin
                  nas_in = col_base + CW'(1);
                  if (whole_word_ff) begin
                     if (start == '0 || !is_alnum(bnd_byte)) begin
                        pend_in = 1'b1;
                        pcol_in = start;
                     end
                  end else if (!pend_fire && rc_mid < max_results_ff) begin
                     imm_fire  = 1'b1;
                     rcount_in = sat_inc(rc_mid);
                  end
               end
            end
         end

         if (pend_fire) begin
            rsp_valid_in = 1'b1;
            rsp_file_in  = file_ff;
            rsp_line_in  = line_ff;
            rsp_col_in   = column_type'(pcol_ff);
         end else if (imm_fire) begin
            rsp_valid_in = 1'b1;
            rsp_file_in  = file_mid;
            rsp_line_in  = line_base;
            rsp_col_in   = column_type'(start);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         nas_ff       <= '0;
         pcol_ff      <= '0;
         pend_ff      <= 1'b0;
         line_ff      <= count_type'(1);
         file_ff      <= '0;
         rcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         nas_ff       <= nas_in;
         pcol_ff      <= pcol_in;
         pend_ff      <= pend_in;
         line_ff      <= line_in;
         file_ff      <= file_in;
         rcount_ff    <= rcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (pend_fire || imm_fire)) begin
         rsp_len_ff <= qlen;
      end
      rsp_file_ff <= rsp_file_in;
      rsp_line_ff <= rsp_line_in;
      rsp_col_ff  <= rsp_col_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.file_number  = rsp_file_ff;
   assign rsp_chan.line_number  = rsp_line_ff;
   assign rsp_chan.column       = rsp_col_ff;
   assign rsp_chan.match_length = rsp_len_ff;

endmodule : literal_text_match_scanner
`default_nettype wire
